// ===== rtl/lpht_pkg.sv =====
// Package for the linear probing hash table: sizes, opcodes, hash and state types.
`default_nettype none
package lpht_pkg;
  localparam int unsigned SLOTS = 1024;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [31:0] HASH_MULT = 32'h9E3779B1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_RESP,
    ST_CLEAR,
    ST_INIT
  } state_t;

  // Memory access request from the controller to the slot store.
  // The clear bit writes an empty mark into the slot at wr_addr.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic             wr_key;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wdata_key;
    logic [31:0]      wdata_val;
    logic             clear;
  } mem_req_t;

  // Registered read data from the slot store.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] val;
  } mem_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/lpht_store.sv =====
// Slot store: key, value and slot-valid memories with registered reads.
`default_nettype none
module lpht_store import lpht_pkg::*; (
  input  wire logic     clk,
  input  wire mem_req_t req,
  output mem_rsp_t      rsp
);
  logic [31:0] key_mem [SLOTS];
  logic [31:0] val_mem [SLOTS];
  logic        valid_mem [SLOTS];

  // Key and value memories, registered read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      val_mem[req.wr_addr] <= req.wdata_val;
      if (req.wr_key) begin
        key_mem[req.wr_addr] <= req.wdata_key;
      end
    end
    if (req.rd_en) begin
      rsp.key   <= key_mem[req.rd_addr];
      rsp.val   <= val_mem[req.rd_addr];
      rsp.valid <= valid_mem[req.rd_addr];
    end
  end

  // Valid marks are set by a new key and emptied one slot a cycle by the clearing pass.
  always_ff @(posedge clk) begin
    if (req.clear) begin
      valid_mem[req.wr_addr] <= 1'b0;
    end else if (req.wr_en && req.wr_key) begin
      valid_mem[req.wr_addr] <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lpht_ctrl.sv =====
// Probe controller: hashes the key, walks slots, updates and answers.
`default_nettype none
module lpht_ctrl import lpht_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_value,
  input  wire logic [9:0]  max_entries,
  output mem_req_t         req,
  input  wire mem_rsp_t    rsp,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [33:0]      out_data
);
  state_t state_r, state_nxt;
  opcode_t op_r;
  logic [31:0] key_r, val_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic [CNT_W-1:0] limit;
  logic [33:0] res_r, res_nxt;
  logic [31:0] hash;
  logic full;

  assign hash = in_key * HASH_MULT;
  assign limit = ({1'b0, max_entries} > CNT_W'(SLOTS - 1)) ? CNT_W'(SLOTS - 1)
                                                          : CNT_W'(max_entries);
  assign full = cnt_r >= limit;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_RESP);
  assign out_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
    steps_r <= steps_nxt;
    res_r   <= res_nxt;
    if (in_valid && in_ready) begin
      op_r  <= opcode_t'(in_opcode);
      key_r <= in_key;
      val_r <= in_value;
    end
  end

  // Next state; result word is {status, value_out, found}.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    steps_nxt = steps_r;
    res_nxt   = res_r;
    req       = '0;
    req.rd_addr   = idx_r;
    req.wr_addr   = idx_r;
    req.wdata_key = key_r;
    req.wdata_val = val_r;
    unique case (state_r)
      ST_INIT: begin
        // Clearing pass after reset, one slot per cycle.
        req.clear = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          idx_nxt   = hash[31 -: IDX_W];
          steps_nxt = '0;
          res_nxt   = '0;
          if (in_opcode == OP_CLEAR) begin
            idx_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_CLEAR;
          end else if (in_opcode == OP_NONE) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_CLEAR: begin
        // Clear operation walks every slot, then answers.
        req.clear = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = ST_RESP;
        end
      end
      ST_READ: begin
        req.rd_en = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = ST_RESP;
        if (!rsp.valid) begin
          // Empty slot ends the probe: key absent.
          if (op_r == OP_PUT) begin
            if (full) begin
              res_nxt[33] = 1'b1;
            end else begin
              req.wr_en  = 1'b1;
              req.wr_key = 1'b1;
              cnt_nxt    = cnt_r + 1'b1;
            end
          end
        end else if (rsp.key == key_r) begin
          res_nxt[0] = 1'b1;
          if (op_r == OP_PUT) begin
            req.wr_en = 1'b1;
          end else begin
            res_nxt[32:1] = rsp.val;
          end
        end else if (steps_r == CNT_W'(SLOTS - 1)) begin
          // Every slot probed without a match or a hole.
          if (op_r == OP_PUT) begin
            res_nxt[33] = 1'b1;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          steps_nxt = steps_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_RESP: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the linear probing hash table.
//  channel  | dir | handshake               | payload
//  in_      | in  | in_tvalid / in_tready   | in_tdata: opcode, key, value
//  out_     | out | out_tvalid / out_tready | out_tdata: found, value_out, status
//  cfg_     | in  | cfg_valid / cfg_ready   | cfg_data: max_entries
// A put or get: the idle state takes the transfer, each probed slot is one read of the
// slot store (ST_READ) and one compare (ST_CHECK), and ST_RESP offers the result.
// A clear empties the 1024 slots one per cycle; an unused opcode goes straight to
// ST_RESP. After reset the same clearing pass runs, in_tready low.
// A stalled result holds the block; the next item is taken after its transfer.
`default_nettype none
module linear_probe_hash_table import lpht_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // opcode[1:0], key[33:2], value[65:34], zeros
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // found[0], value_out[32:1], status[33], zeros
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // max_entries[9:0], zeros
);
  mem_req_t req;
  mem_rsp_t rsp;
  logic [9:0] max_r;
  logic [33:0] res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= 10'd767;
    end else if (cfg_valid) begin
      max_r <= cfg_data[9:0];
    end
  end

  lpht_store u_store (.clk, .req, .rsp);

  lpht_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_opcode(in_tdata[1:0]), .in_key(in_tdata[33:2]), .in_value(in_tdata[65:34]),
    .max_entries(max_r), .req, .rsp,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(res)
  );

  assign out_tdata = {6'd0, res};

  // A full status never comes with found.
  a_full_nf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[33] && out_tdata[0])) else $error("full with found");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  // No input is taken while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready)) else $error("overlap");
endmodule
`default_nettype wire

// ===== dv/lpht_checker.sv =====
// Checker for the hash table: predicts each result from accepted operations and compares.
`default_nettype none
module lpht_checker import lpht_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [71:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic        found;
    logic [31:0] value_out;
    logic        status;
  } table_result_t;

  // Shadow copy of the table contents.
  logic [31:0]      shadow_key [SLOTS];
  logic [31:0]      shadow_val [SLOTS];
  logic             shadow_used [SLOTS];
  int unsigned      shadow_count;
  logic [9:0]       shadow_limit;
  table_result_t    expected_results[$];

  function automatic logic [IDX_W-1:0] home_of(input logic [31:0] key);
    logic [31:0] h;
    logic [63:0] prod;
    h = key * HASH_MULT;
    prod = {32'd0, h} * SLOTS;
    return prod[32 +: IDX_W];
  endfunction

  // Walks the probe chain; returns hit, and in slot the hit or first empty slot.
  function automatic logic find_slot(input logic [31:0] key, output int unsigned slot);
    int unsigned i;
    i = home_of(key);
    for (int n = 0; n < SLOTS; n++) begin
      if (!shadow_used[i]) begin
        slot = i;
        return 1'b0;
      end
      if (shadow_key[i] == key) begin
        slot = i;
        return 1'b1;
      end
      i = (i + 1) % SLOTS;
    end
    slot = i;
    return 1'b0;
  endfunction

  function automatic table_result_t apply_operation(input logic [71:0] item);
    opcode_t       op;
    logic [31:0]   key;
    logic [31:0]   val;
    table_result_t r;
    int unsigned   slot;
    int unsigned   cap;
    op  = opcode_t'(item[1:0]);
    key = item[33:2];
    val = item[65:34];
    r   = '0;
    case (op)
      OP_PUT: begin
        cap = (shadow_limit > SLOTS - 1) ? SLOTS - 1 : shadow_limit;
        if (find_slot(key, slot)) begin
          shadow_val[slot] = val;
          r.found = 1'b1;
        end else if (shadow_count >= cap || shadow_used[slot]) begin
          r.status = 1'b1;
        end else begin
          shadow_key[slot]  = key;
          shadow_val[slot]  = val;
          shadow_used[slot] = 1'b1;
          shadow_count++;
        end
      end
      OP_GET: begin
        if (find_slot(key, slot)) begin
          r.found = 1'b1;
          r.value_out = shadow_val[slot];
        end
      end
      OP_CLEAR: begin
        foreach (shadow_used[i]) shadow_used[i] = 1'b0;
        shadow_count = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Track transfers on every channel and compare results in order.
  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (!rst_n) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      shadow_count = 0;
      shadow_limit = 10'd767;
      expected_results.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) shadow_limit = cfg_data[9:0];
      if (out_tvalid && out_tready) begin
        got.found     = out_tdata[0];
        got.value_out = out_tdata[32:1];
        got.status    = out_tdata[33];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result found=%0b value_out=%h status=%0b",
                   $time, got.found, got.value_out, got.status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: expected found=%0b value_out=%h status=%0b,",
                     $time, want.found, want.value_out, want.status,
                     " got found=%0b value_out=%h status=%0b",
                     got.found, got.value_out, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) expected_results.push_back(apply_operation(in_tdata));
      pending <= expected_results.size();
    end
  end
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Top of the hash table testbench: clock, reset, stimulus and verdict.
`default_nettype none
module tb_top;
  import lpht_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          quiet_phase = 1'b0;

  // Keys sent in puts, reused so gets and updates can hit.
  logic [31:0] used_keys[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  linear_probe_hash_table dut (.*);

  lpht_checker checker_i (.*);

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 20000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stalls in random bursts.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_op(input opcode_t op, input logic [31:0] key, input logic [31:0] val);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tdata  <= {6'd0, val, key, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_PUT) used_keys.push_back(key);
    if (op == OP_CLEAR) used_keys.delete();
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input logic [9:0] limit);
    cfg_data  <= {6'd0, limit};
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(0, 2) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 15);
    return $urandom();
  endfunction

  task automatic random_phase(input int count, input int put_weight);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < put_weight) send_op(OP_PUT, pick_key(), $urandom());
      else if (r < 97) send_op(OP_GET, pick_key(), $urandom());
      else if (r < 99) send_op(OP_NONE, $urandom(), $urandom());
      else send_op(OP_CLEAR, $urandom(), $urandom());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every opcode, update, missing key, unused opcode, clear.
    send_op(OP_GET, 32'h0, 32'h0);
    send_op(OP_PUT, 32'h0, 32'hFFFFFFFF);
    send_op(OP_PUT, 32'hFFFFFFFF, 32'h0);
    send_op(OP_GET, 32'h0, 32'h0);
    send_op(OP_GET, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_op(OP_PUT, 32'h0, 32'hA5A5A5A5);
    send_op(OP_GET, 32'h0, 32'h0);
    send_op(OP_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_op(OP_GET, 32'h12345678, 32'h0);
    send_op(OP_CLEAR, 32'h0, 32'h0);
    send_op(OP_GET, 32'h0, 32'h0);
    settle();

    // Tiny limit: full rejects, updates still allowed.
    write_limit(10'd2);
    for (int k = 0; k < 4; k++) send_op(OP_PUT, k, $urandom());
    send_op(OP_PUT, 32'd1, 32'hDEADBEEF);
    send_op(OP_GET, 32'd1, 32'd0);
    send_op(OP_CLEAR, 32'd0, 32'd0);
    settle();

    // Zero limit rejects every new key.
    write_limit(10'd0);
    send_op(OP_PUT, 32'd7, 32'd7);
    send_op(OP_GET, 32'd7, 32'd0);
    settle();

    write_limit(10'd40);
    random_phase(400, 55);
    settle();

    // Largest limit, capped to keep one slot empty.
    write_limit(10'd1023);
    random_phase(450, 60);
    settle();

    // Reset value again; the last part runs without idling.
    write_limit(10'd767);
    send_op(OP_CLEAR, 32'd0, 32'd0);
    random_phase(420, 50);
    quiet_phase = 1'b1;
    random_phase(150, 45);
    settle();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/lpht_pkg.sv
rtl/lpht_store.sv
rtl/lpht_ctrl.sv
rtl/linear_probe_hash_table.sv
dv/lpht_checker.sv
dv/tb_top.sv
